### design/ljwbe_pkg.sv
`default_nettype none
package ljwbe_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned SigW   = 20;
  localparam int unsigned EpsW   = 24;
  localparam int unsigned RatW   = 36;
  localparam int unsigned QW     = 48;
  localparam int unsigned EnW    = 48;
  localparam int unsigned DivLat = RatW;
  localparam int unsigned MulLat = 2;
  localparam int unsigned PowLat = DivLat + 4 * MulLat;
  localparam int unsigned WallLat = PowLat + 4;

  localparam logic [PosW-1:0] CUT_RESET  = 24'd655360;
  localparam logic [EnW-1:0]  OUT_ENERGY = 48'd58982400000;
  localparam logic [EnW-1:0]  EMAX       = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [EpsW-1:0] eps;
    logic            en;
    logic            zero;
  } wall_side_t;

  typedef struct packed {
    logic valid;
    logic oob;
  } top_side_t;

endpackage
`default_nettype wire

### design/ljwbe_qmul.sv
`default_nettype none
module ljwbe_qmul (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ljwbe_pkg::QW-1:0] a_i,
  input  logic [ljwbe_pkg::QW-1:0] b_i,
  input  logic [ljwbe_pkg::QW-1:0] aux_i,
  input  logic                    flag_i,
  output logic [ljwbe_pkg::QW-1:0] res_o,
  output logic [ljwbe_pkg::QW-1:0] aux_o,
  output logic                    flag_o
);

  logic [47:0] hh_q, hl_q, lh_q, ll_q;
  logic [47:0] aux1_q, aux2_q, res_q;
  logic        flag1_q, flag2_q;
  logic [48:0] mid;
  logic [95:0] prod;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= 48'(a_i[47:24]) * 48'(b_i[47:24]);
      hl_q    <= 48'(a_i[47:24]) * 48'(b_i[23:0]);
      lh_q    <= 48'(a_i[23:0]) * 48'(b_i[47:24]);
      ll_q    <= 48'(a_i[23:0]) * 48'(b_i[23:0]);
      aux1_q  <= aux_i;
      flag1_q <= flag_i;
    end
  end

  always_comb begin
    mid  = 49'(hl_q) + 49'(lh_q);
    prod = {hh_q, 48'd0} + {23'd0, mid, 24'd0} + {48'd0, ll_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= prod[63:16];
      aux2_q  <= aux1_q;
      flag2_q <= flag1_q | (|prod[95:64]);
    end
  end

  assign res_o  = res_q;
  assign aux_o  = aux2_q;
  assign flag_o = flag2_q;

endmodule
`default_nettype wire

### design/ljwbe_wall.sv
`default_nettype none
module ljwbe_wall (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ljwbe_pkg::PosW-1:0] dist_i,
  input  logic [ljwbe_pkg::SigW-1:0] sigma_i,
  input  logic [ljwbe_pkg::EpsW-1:0] epsilon_i,
  input  logic                       active_i,
  output logic [ljwbe_pkg::EnW-1:0]  term_o,
  output logic                       sat_o
);

  localparam int unsigned NDiv = ljwbe_pkg::DivLat;
  localparam int unsigned NPow = ljwbe_pkg::PowLat;

  logic [23:0] dv_q  [NDiv];
  logic [35:0] num_q [NDiv];
  logic [35:0] quo_q [NDiv];
  logic [23:0] rem_q [NDiv];

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [23:0] d_in, rem_in;
    logic [35:0] num_in, quo_in, quo_nx;
    logic [24:0] trial;
    logic        ge;
    if (k == 0) begin : g_first
      assign d_in   = dist_i;
      assign num_in = {sigma_i, 16'd0};
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign d_in   = dv_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
    end
    assign trial  = {rem_in, num_in[35-k]};
    assign ge     = trial >= {1'b0, d_in};
    assign quo_nx = quo_in | (36'(ge) << (35 - k));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k]  <= d_in;
        num_q[k] <= num_in;
        quo_q[k] <= quo_nx;
        rem_q[k] <= ge ? 24'(trial - {1'b0, d_in}) : trial[23:0];
      end
    end
  end

  ljwbe_pkg::wall_side_t side_q [NPow];
  ljwbe_pkg::wall_side_t side_in;

  assign side_in = '{eps: epsilon_i, en: active_i, zero: (dist_i == '0)};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_in;
      for (int i = 1; i < NPow; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [47:0] r, r2, r_d, r3, r6, r3_d, r9, r3_e, nul_aux;
  logic        f2, f3, f6, f9;

  assign r = 48'(quo_q[NDiv-1]);

  ljwbe_qmul u_r2 (
    .clk_i, .en_i, .a_i(r), .b_i(r), .aux_i(r), .flag_i(1'b0),
    .res_o(r2), .aux_o(r_d), .flag_o(f2)
  );
  ljwbe_qmul u_r3 (
    .clk_i, .en_i, .a_i(r2), .b_i(r_d), .aux_i(48'd0), .flag_i(f2),
    .res_o(r3), .aux_o(nul_aux), .flag_o(f3)
  );
  ljwbe_qmul u_r6 (
    .clk_i, .en_i, .a_i(r3), .b_i(r3), .aux_i(r3), .flag_i(f3 | (|nul_aux & 1'b0)),
    .res_o(r6), .aux_o(r3_d), .flag_o(f6)
  );
  ljwbe_qmul u_r9 (
    .clk_i, .en_i, .a_i(r6), .b_i(r3_d), .aux_i(r3_d), .flag_i(f6),
    .res_o(r9), .aux_o(r3_e), .flag_o(f9)
  );

  logic [48:0] diff;
  logic [47:0] mag_q;
  logic        neg_q, ovf_q;
  ljwbe_pkg::wall_side_t sd_q, se_q, sf_q;

  assign diff = {1'b0, r9} - {1'b0, r3_e};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= diff[48];
      mag_q <= diff[48] ? 48'(-diff) : diff[47:0];
      ovf_q <= f9;
      sd_q  <= side_q[NPow-1];
    end
  end

  logic [47:0] ph_q, pl_q;
  logic        neg2_q, ovf2_q, neg3_q, ovf3_q;
  logic [71:0] eprod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q    <= 48'(mag_q[47:24]) * 48'(sd_q.eps);
      pl_q    <= 48'(mag_q[23:0]) * 48'(sd_q.eps);
      neg2_q  <= neg_q;
      ovf2_q  <= ovf_q;
      se_q    <= sd_q;
      eprod_q <= {ph_q, 24'd0} + {24'd0, pl_q};
      neg3_q  <= neg2_q;
      ovf3_q  <= ovf2_q;
      sf_q    <= se_q;
    end
  end

  logic [63:0] rnd;
  logic [47:0] term_d, term_q;
  logic        big, eps_nz, sat_d, sat_q;

  always_comb begin
    rnd    = eprod_q[63:0] + 64'hF_FFFF;
    big    = |eprod_q[71:65];
    eps_nz = sf_q.eps != '0;
    if (neg3_q) begin
      term_d = 48'(-{2'b00, rnd[63:20], 2'b00});
    end else begin
      term_d = {1'b0, eprod_q[64:20], 2'b00};
    end
    sat_d = sf_q.en & (sf_q.zero | (eps_nz & (ovf3_q | (big & ~neg3_q))));
    if (!sf_q.en || sf_q.zero || !eps_nz) begin
      term_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
      sat_q  <= sat_d;
    end
  end

  assign term_o = term_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire

### design/lj_wall_bead_energy.sv
// Channel  | Handshake                | Payload
// in       | in_valid_i / in_stall_o  | z_position_i, box_height_i, sigma_i, epsilon_i
// out      | out_valid_o / out_stall_i| energy_o, out_of_box_o, saturated_o
// cfg      | cfg_we_i                 | cfg_wdata_i (cut distance)
// One item per cycle unless a valid result is stalled; each result passes through
// the 36-stage quotient pipeline, four 2-stage products and the epsilon scaling.
// Reset clears the valid bits and loads the cut distance with 10.0.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module lj_wall_bead_energy (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] z_position_i,
  input  logic [23:0] box_height_i,
  input  logic [19:0] sigma_i,
  input  logic [23:0] epsilon_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] energy_o,
  output logic        out_of_box_o,
  output logic        saturated_o
);

  localparam int unsigned NLat = ljwbe_pkg::WallLat;

  logic [23:0] cut_q;
  logic        adv;
  logic        out_valid_q;

  assign adv        = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= ljwbe_pkg::CUT_RESET;
    end else if (cfg_we_i) begin
      cut_q <= cfg_wdata_i;
    end
  end

  logic [23:0] d1;
  logic [23:0] d0_q, d1_q, eps_q;
  logic [19:0] sig_q;
  logic        en0_q, en1_q;
  ljwbe_pkg::top_side_t s0_q;
  ljwbe_pkg::top_side_t line_q [NLat];

  assign d1 = box_height_i - z_position_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      for (int i = 0; i < NLat; i++) begin
        line_q[i] <= '0;
      end
    end else if (adv) begin
      s0_q.valid <= in_valid_i;
      s0_q.oob   <= z_position_i[23] | (z_position_i > box_height_i);
      line_q[0]  <= s0_q;
      for (int i = 1; i < NLat; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d0_q  <= z_position_i;
      d1_q  <= d1;
      en0_q <= z_position_i < cut_q;
      en1_q <= d1 < cut_q;
      sig_q <= sigma_i;
      eps_q <= epsilon_i;
    end
  end

  logic [47:0] t0, t1;
  logic        sat0, sat1;

  ljwbe_wall u_wall_lo (
    .clk_i, .en_i(adv), .dist_i(d0_q), .sigma_i(sig_q), .epsilon_i(eps_q),
    .active_i(en0_q), .term_o(t0), .sat_o(sat0)
  );
  ljwbe_wall u_wall_hi (
    .clk_i, .en_i(adv), .dist_i(d1_q), .sigma_i(sig_q), .epsilon_i(eps_q),
    .active_i(en1_q), .term_o(t1), .sat_o(sat1)
  );

  logic [48:0] sum;
  logic        sat_any;
  logic [47:0] energy_d, energy_q;
  logic        oob_q, sat_q;

  always_comb begin
    sum     = {t0[47], t0} + {t1[47], t1};
    sat_any = sat0 | sat1 | (~sum[48] & sum[47]);
    if (line_q[NLat-1].oob) begin
      energy_d = ljwbe_pkg::OUT_ENERGY;
    end else if (sat_any) begin
      energy_d = ljwbe_pkg::EMAX;
    end else begin
      energy_d = sum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= line_q[NLat-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      energy_q <= energy_d;
      oob_q    <= line_q[NLat-1].oob;
      sat_q    <= ~line_q[NLat-1].oob & sat_any;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign energy_o     = energy_q;
  assign out_of_box_o = oob_q;
  assign saturated_o  = sat_q;

endmodule
`default_nettype wire

### design/ljwbe_chk.sv
`default_nettype none
module ljwbe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] energy_o,
  input logic        out_of_box_o,
  input logic        saturated_o
);

  a_oob_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_box_o |-> !saturated_o)
    else $error("out-of-box item flagged saturated");

  a_oob_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_box_o |-> energy_o == ljwbe_pkg::OUT_ENERGY)
    else $error("out-of-box energy wrong");

  a_sat_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> energy_o == ljwbe_pkg::EMAX)
    else $error("saturated energy not clipped");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(energy_o))
    else $error("stalled item changed");

endmodule

bind lj_wall_bead_energy ljwbe_chk u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .energy_o, .out_of_box_o, .saturated_o
);
`default_nettype wire
